### rtl/generational_slot_allocator_macros.svh
// assertion macros shared by the slot allocator rtl
`ifndef GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define GSA_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("slot allocator check failed");

// next-cycle implication
`define GSA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("slot allocator check failed");

`endif

### rtl/gsa_pkg.sv
// types and constants of the slot allocator
`timescale 1ns / 1ps

package gsa_pkg;

    localparam int SLOT_FIELD_W    = 8;
    localparam int GEN_FIELD_W     = 32;
    localparam int SLOT_FIELD_SPAN = 256;
    localparam int DEF_SLOT_COUNT  = 256;
    localparam int DEF_GEN_BITS    = 32;
    localparam int GROUP_SIZE      = 16;
    localparam int GROUP_SEL_W     = 4;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    typedef struct packed {
        logic [1:0]             command;
        logic [SLOT_FIELD_W-1:0] slot;
        logic                   handle_null;
        logic [GEN_FIELD_W-1:0] expected_generation;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] granted_slot;
        logic                   out_of_slots;
        logic [GEN_FIELD_W-1:0] generation_now;
        logic                   still_live;
    } t_out_item;

    // request to the in-use map
    typedef struct packed {
        logic                    alloc_en;
        logic                    free_en;
        logic [SLOT_FIELD_W-1:0] slot;
    } t_map_req;

    typedef struct packed {
        logic                    found;
        logic [SLOT_FIELD_W-1:0] grant;
    } t_map_rsp;

    // generation memory port control
    typedef struct packed {
        logic                    rd_en;
        logic [SLOT_FIELD_W-1:0] rd_addr;
        logic                    wr_en;
        logic [SLOT_FIELD_W-1:0] wr_addr;
    } t_mem_ctl;

endpackage

### rtl/gsa_slot_map.sv
// in-use bits with group summary and lowest-free-slot search
`timescale 1ns / 1ps
`include "generational_slot_allocator_macros.svh"

module gsa_slot_map #(
    parameter int SLOT_COUNT = gsa_pkg::DEF_SLOT_COUNT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gsa_pkg::t_map_req i_req,
    output gsa_pkg::t_map_rsp o_rsp
);
    import gsa_pkg::*;

    localparam int SLOT_DEPTH  = (SLOT_COUNT < SLOT_FIELD_SPAN) ? SLOT_COUNT : SLOT_FIELD_SPAN;
    localparam int IDX_W       = $clog2(SLOT_DEPTH);
    localparam int GROUP_COUNT = (SLOT_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_W       = GROUP_COUNT * GROUP_SIZE;
    localparam int GRP_W       = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

    logic [SLOT_DEPTH-1:0]      r_in_use;
    logic [SLOT_DEPTH-1:0]      n_in_use;
    logic [GROUP_COUNT-1:0]     r_grp_full;
    logic [GROUP_COUNT-1:0]     n_grp_full;
    logic [PAD_W-1:0]           w_padded;
    logic [PAD_W-1:0]           n_padded;
    logic [GRP_W-1:0]           w_grp_idx;
    logic                       w_any;
    logic [GROUP_SIZE-1:0]      w_grp_bits;
    logic [GROUP_SEL_W-1:0]     w_bit_idx;
    logic [GRP_W+GROUP_SEL_W-1:0] w_grant_wide;
    logic [IDX_W-1:0]           w_grant_idx;

    // padding past the pool reads as used
    always_comb begin
        w_padded = '1;
        w_padded[SLOT_DEPTH-1:0] = r_in_use;
    end

    // first group that still has a free slot
    always_comb begin
        w_grp_idx = '0;
        w_any     = 1'b0;
        for (int g = GROUP_COUNT - 1; g >= 0; g--) begin
            if (!r_grp_full[g]) begin
                w_grp_idx = GRP_W'(g);
                w_any     = 1'b1;
            end
        end
    end

    assign w_grp_bits = w_padded[w_grp_idx * GROUP_SIZE +: GROUP_SIZE];

    always_comb begin
        w_bit_idx = '0;
        for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
            if (!w_grp_bits[b]) begin
                w_bit_idx = GROUP_SEL_W'(b);
            end
        end
    end

    assign w_grant_wide = {w_grp_idx, w_bit_idx};
    assign w_grant_idx  = IDX_W'(w_grant_wide);
    assign o_rsp.found  = w_any;
    assign o_rsp.grant  = SLOT_FIELD_W'(w_grant_wide);

    always_comb begin
        n_in_use = r_in_use;
        if (i_req.alloc_en && w_any) begin
            n_in_use[w_grant_idx] = 1'b1;
        end
        if (i_req.free_en) begin
            n_in_use[i_req.slot[IDX_W-1:0]] = 1'b0;
        end
        n_padded = '1;
        n_padded[SLOT_DEPTH-1:0] = n_in_use;
        for (int g = 0; g < GROUP_COUNT; g++) begin
            n_grp_full[g] = &n_padded[g * GROUP_SIZE +: GROUP_SIZE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use   <= '0;
            r_grp_full <= '0;
        end else begin
            r_in_use   <= n_in_use;
            r_grp_full <= n_grp_full;
        end
    end

    `GSA_ASSERT_NEXT(a_grant_marked_used, i_clk, i_rst_n, i_req.alloc_en && w_any, r_in_use[$past(w_grant_idx)])
    `GSA_ASSERT_NEXT(a_free_clears_bit, i_clk, i_rst_n, i_req.free_en, !r_in_use[$past(i_req.slot[IDX_W-1:0])])

endmodule

### rtl/gsa_gen_mem.sv
// generation memory with per-entry valid bits and write-to-read forwarding
`timescale 1ns / 1ps

module gsa_gen_mem #(
    parameter int SLOT_COUNT = gsa_pkg::DEF_SLOT_COUNT,
    parameter int GEN_BITS   = gsa_pkg::DEF_GEN_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gsa_pkg::t_mem_ctl    i_ctl,
    input  logic [GEN_BITS-1:0]  i_wr_data,
    output logic [GEN_BITS-1:0]  o_rd_data
);
    import gsa_pkg::*;

    localparam int SLOT_DEPTH = (SLOT_COUNT < SLOT_FIELD_SPAN) ? SLOT_COUNT : SLOT_FIELD_SPAN;
    localparam int IDX_W      = $clog2(SLOT_DEPTH);

    logic [GEN_BITS-1:0]   mem [SLOT_DEPTH];
    logic [SLOT_DEPTH-1:0] r_written;
    logic [GEN_BITS-1:0]   r_q;
    logic                  r_q_ok;
    logic                  r_fwd;
    logic [GEN_BITS-1:0]   r_fwd_data;
    logic [IDX_W-1:0]      w_ra;
    logic [IDX_W-1:0]      w_wa;
    logic                  w_hit;

    assign w_ra  = i_ctl.rd_addr[IDX_W-1:0];
    assign w_wa  = i_ctl.wr_addr[IDX_W-1:0];
    assign w_hit = i_ctl.wr_en && (w_wa == w_ra);

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[w_wa] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_q        <= mem[w_ra];
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_q_ok    <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_written[w_wa] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_q_ok <= r_written[w_ra];
                r_fwd  <= w_hit;
            end
        end
    end

    // entries never written read as zero
    assign o_rd_data = r_fwd ? r_fwd_data : (r_q_ok ? r_q : '0);

endmodule

### rtl/generational_slot_allocator.sv
// top level of the generational slot allocator
`timescale 1ns / 1ps
`include "generational_slot_allocator_macros.svh"

// Handle allocator over a pool of slots, each with an in-use bit and a generation.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one command per beat:
// allocate, free, check or read. Output channel (o_out_valid / i_out_ready /
// o_out_data) returns exactly one result beat per command, in order.
// An accepted command waits in the working stage; its result is registered in the
// output register as that stage advances (o_out_valid rises). Throughput: one
// command per cycle sustained while i_out_ready stays high. Allocation is decided
// at accept from the in-use flops; the generation memory is read at accept and
// written back as the command leaves the working stage; a pending write is
// forwarded to a same-slot read, so the read-modify-write loop sets the rate.
// Reset (i_rst_n low, synchronous) frees every slot and makes every generation
// read as zero at once; there is no clearing pass.
// When the receiver stalls, the result waits in the output register, one more
// command is taken into the working stage, and o_in_ready then drops until the
// output drains.

module generational_slot_allocator #(
    parameter int SLOT_COUNT = gsa_pkg::DEF_SLOT_COUNT,
    parameter int GEN_BITS   = gsa_pkg::DEF_GEN_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gsa_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output gsa_pkg::t_out_item o_out_data
);
    import gsa_pkg::*;

    localparam int CMP_W = (GEN_BITS > GEN_FIELD_W) ? GEN_BITS : GEN_FIELD_W;

    t_map_req              w_map_req;
    t_map_rsp              w_map_rsp;
    t_mem_ctl              w_mem_ctl;
    logic [GEN_BITS-1:0]   w_gen_cur;
    logic [GEN_BITS-1:0]   w_gen_inc;
    logic                  w_take;
    logic                  w_adv;
    logic                  w_slot_ok;
    logic [SLOT_FIELD_W-1:0] w_slot_sel;
    logic                  w_oos_clean;

    logic                  r_busy;
    logic [1:0]            r_cmd;
    logic                  r_slot_ok;
    logic                  r_null;
    logic [GEN_FIELD_W-1:0] r_expected;
    logic                  r_found;
    logic [SLOT_FIELD_W-1:0] r_addr;
    logic                  r_out_valid;
    t_out_item             r_out_data;
    t_out_item             n_out_data;

    assign w_adv      = r_busy && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_busy || w_adv;
    assign w_take     = i_in_valid && o_in_ready;
    assign w_slot_ok  = (32'(i_in_data.slot) < 32'(SLOT_COUNT));
    assign w_slot_sel = w_slot_ok ? i_in_data.slot : '0;

    assign w_map_req.alloc_en = w_take && (i_in_data.command == CMD_ALLOC);
    assign w_map_req.free_en  = w_take && (i_in_data.command == CMD_FREE) && w_slot_ok;
    assign w_map_req.slot     = w_slot_sel;

    gsa_slot_map #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slot_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_map_req),
        .o_rsp   (w_map_rsp)
    );

    // allocate reads the granted slot, the rest read the addressed one
    assign w_mem_ctl.rd_en   = w_take;
    assign w_mem_ctl.rd_addr = (i_in_data.command == CMD_ALLOC) ? w_map_rsp.grant : w_slot_sel;
    assign w_mem_ctl.wr_en   = w_adv && (r_cmd == CMD_FREE) && r_slot_ok;
    assign w_mem_ctl.wr_addr = r_addr;

    gsa_gen_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .GEN_BITS   (GEN_BITS)
    ) u_gen_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_mem_ctl),
        .i_wr_data (w_gen_inc),
        .o_rd_data (w_gen_cur)
    );

    assign w_gen_inc = w_gen_cur + GEN_BITS'(1);

    always_comb begin
        n_out_data = '0;
        unique case (r_cmd)
            CMD_ALLOC: begin
                n_out_data.out_of_slots = !r_found;
                if (r_found) begin
                    n_out_data.granted_slot   = r_addr;
                    n_out_data.generation_now = GEN_FIELD_W'(w_gen_cur);
                end
            end
            CMD_FREE: begin
                if (r_slot_ok) begin
                    n_out_data.generation_now = GEN_FIELD_W'(w_gen_inc);
                end
            end
            CMD_CHECK: begin
                if (r_slot_ok) begin
                    n_out_data.generation_now = GEN_FIELD_W'(w_gen_cur);
                    n_out_data.still_live = !r_null
                        && (CMP_W'(w_gen_cur) == CMP_W'(r_expected));
                end
            end
            default: begin
                if (r_slot_ok) begin
                    n_out_data.generation_now = GEN_FIELD_W'(w_gen_cur);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd      <= i_in_data.command;
            r_slot_ok  <= w_slot_ok;
            r_null     <= i_in_data.handle_null;
            r_expected <= i_in_data.expected_generation;
            r_found    <= w_map_rsp.found;
            r_addr     <= w_mem_ctl.rd_addr;
        end
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_busy <= 1'b1;
            end else if (w_adv) begin
                r_busy <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_oos_clean = (r_out_data.granted_slot == '0) && (r_out_data.generation_now == '0)
                         && !r_out_data.still_live;

    `GSA_ASSERT_IMPL(a_take_moves_stage, i_clk, i_rst_n, w_take && r_busy, w_adv)
    `GSA_ASSERT_IMPL(a_oos_result_clean, i_clk, i_rst_n, r_out_valid && r_out_data.out_of_slots, w_oos_clean)

endmodule
